// ----- src/ecis_pkg.sv -----
// ----------------------------------------------------------------------------
// ecis_pkg
// Types and constants shared by the event combiner and interrupt selector.
// ----------------------------------------------------------------------------
package ecis_pkg;

    localparam int MAX_GROUPS   = 4;   // event groups the register map can address
    localparam int MAX_LINES    = 12;  // CPU interrupt lines the result carries
    localparam int GROUP_BITS   = 32;  // events per group
    localparam int SEL_W        = 7;   // width of one line select field
    localparam int NUM_COMBINED = 4;   // events 0 to 3 are the combined events
    localparam int NUM_WORDS    = 4;   // select words, word 0 is reserved

    localparam logic [1:0] OP_RAISE = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [2:0] KIND_FLAGS  = 3'd0;
    localparam logic [2:0] KIND_CLEAR  = 3'd1;
    localparam logic [2:0] KIND_MASK   = 3'd2;
    localparam logic [2:0] KIND_MASKED = 3'd3;
    localparam logic [2:0] KIND_SELECT = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [6:0]  event_number;
        logic [2:0]  register_kind;
        logic [1:0]  register_index;
        logic [31:0] write_data;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [11:0] interrupt_lines;
        logic [4:0]  first_pending;
        logic        any_pending;
    } result_t;

    // Raw event raised by the current transaction, if any
    typedef struct packed {
        logic       hit;
        logic [6:0] number;
    } raise_t;

endpackage

// ----- src/ecis_state.sv -----
// ----------------------------------------------------------------------------
// ecis_state
// Flag, mask and line select registers with their update logic.
// ----------------------------------------------------------------------------
module ecis_state
    import ecis_pkg::*;
#(
    parameter int NUM_GROUPS = 4,
    parameter int NUM_LINES  = 12
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     fire,
    input  item_t                                    item,
    output logic [NUM_GROUPS-1:0][GROUP_BITS-1:0]    flags_next,
    output logic [NUM_GROUPS-1:0][GROUP_BITS-1:0]    mask_next,
    output logic [NUM_LINES-1:0][SEL_W-1:0]          sel_next,
    output raise_t                                   raise
);

    logic [NUM_GROUPS-1:0][GROUP_BITS-1:0] flags_reg;
    logic [NUM_GROUPS-1:0][GROUP_BITS-1:0] mask_reg;
    logic [NUM_LINES-1:0][SEL_W-1:0]       sel_reg;

    logic is_write;

    assign is_write = fire && (item.operation == OP_WRITE);

    // Raise hits only raw events of an existing group
    assign raise.hit = fire && (item.operation == OP_RAISE)
                       && (item.event_number >= 7'(NUM_COMBINED))
                       && ({1'b0, item.event_number[6:5]} < 3'(NUM_GROUPS));
    assign raise.number = item.event_number;

    for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
        logic sel_grp;
        logic set_bit;

        assign sel_grp = (item.register_index == 2'(g));
        assign set_bit = raise.hit && (item.event_number[6:5] == 2'(g));

        always_comb
        begin
            flags_next[g] = flags_reg[g];
            mask_next[g]  = mask_reg[g];
            if (set_bit)
            begin
                flags_next[g][item.event_number[4:0]] = 1'b1;
            end
            if (is_write && sel_grp && item.register_kind == KIND_CLEAR)
            begin
                flags_next[g] = flags_reg[g] & ~item.write_data;
            end
            if (is_write && sel_grp && item.register_kind == KIND_MASK)
            begin
                mask_next[g] = item.write_data;
            end
        end
    end

    for (genvar k = 0; k < NUM_LINES; k++) begin : g_line
        localparam int WORD = k / 4 + 1;
        localparam int BYTE = k % 4;

        always_comb
        begin
            sel_next[k] = sel_reg[k];
            if (is_write && item.register_kind == KIND_SELECT
                && item.register_index == 2'(WORD))
            begin
                sel_next[k] = item.write_data[8*BYTE +: SEL_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            mask_reg  <= '1;
            sel_reg   <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
            mask_reg  <= mask_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

// ----- src/ecis_eval.sv -----
// ----------------------------------------------------------------------------
// ecis_eval
// Read mux, combined events, line drive and pending search for one transaction.
// ----------------------------------------------------------------------------
module ecis_eval
    import ecis_pkg::*;
#(
    parameter int NUM_GROUPS = 4,
    parameter int NUM_LINES  = 12
)
(
    input  item_t                                 item,
    input  logic [NUM_GROUPS-1:0][GROUP_BITS-1:0] flags,
    input  logic [NUM_GROUPS-1:0][GROUP_BITS-1:0] mask,
    input  logic [NUM_LINES-1:0][SEL_W-1:0]       sel,
    input  raise_t                                raise,
    output result_t                               result
);

    logic [MAX_GROUPS-1:0][GROUP_BITS-1:0] flags_all;
    logic [MAX_GROUPS-1:0][GROUP_BITS-1:0] mask_all;
    logic [MAX_GROUPS-1:0][GROUP_BITS-1:0] masked_all;
    logic [MAX_LINES-1:0][SEL_W-1:0]       sel_all;
    logic [NUM_WORDS-1:0][31:0]            words;
    logic [NUM_COMBINED-1:0]               combined;
    logic [GROUP_BITS-1:0]                 pend;
    logic [MAX_LINES-1:0]                  lines;
    logic [4:0]                            first_idx;
    logic [31:0]                           rd_data;

    // Missing groups read as zero everywhere
    for (genvar g = 0; g < MAX_GROUPS; g++) begin : g_group
        if (g < NUM_GROUPS) begin : g_on
            assign flags_all[g]  = flags[g];
            assign mask_all[g]   = mask[g];
            assign masked_all[g] = flags[g] & ~mask[g];
        end
        else begin : g_off
            assign flags_all[g]  = '0;
            assign mask_all[g]   = '0;
            assign masked_all[g] = '0;
        end
        assign combined[g] = |masked_all[g];
    end

    for (genvar k = 0; k < MAX_LINES; k++) begin : g_sel
        if (k < NUM_LINES) begin : g_on
            assign sel_all[k] = sel[k];
            assign lines[k]   = (sel[k] < SEL_W'(NUM_COMBINED))
                                ? combined[sel[k][1:0]]
                                : (raise.hit && (sel[k] == raise.number));
        end
        else begin : g_off
            assign sel_all[k] = '0;
            assign lines[k]   = 1'b0;
        end
    end

    assign words[0] = '0;
    for (genvar w = 1; w < NUM_WORDS; w++) begin : g_word
        for (genvar j = 0; j < 4; j++) begin : g_byte
            assign words[w][8*j +: 8] = {1'b0, sel_all[(w-1)*4 + j]};
        end
    end

    assign pend = masked_all[item.register_index];

    always_comb
    begin
        first_idx = '0;
        for (int b = GROUP_BITS - 1; b >= 0; b--)
        begin
            if (pend[b])
            begin
                first_idx = 5'(b);
            end
        end
    end

    always_comb
    begin
        rd_data = '0;
        if (item.operation == OP_READ)
        begin
            case (item.register_kind)
                KIND_FLAGS:  rd_data = flags_all[item.register_index];
                KIND_MASK:   rd_data = mask_all[item.register_index];
                KIND_MASKED: rd_data = masked_all[item.register_index];
                KIND_SELECT: rd_data = words[item.register_index];
                default:     rd_data = '0;
            endcase
        end
    end

    // Pack in field order: read data, lines, first pending, any pending
    assign result = {rd_data, lines, first_idx, |pend};

endmodule

// ----- src/event_combiner_interrupt_selector.sv -----
// ----------------------------------------------------------------------------
// event_combiner_interrupt_selector
// Interrupt event combiner with per-group masks and selectable CPU lines.
// ----------------------------------------------------------------------------
// Each transaction raises an event, writes a register or reads one, and
// returns exactly one result. A transaction is captured in an input register.
// When it moves into the result register it updates the flag, mask and
// select registers, while its result (read data, line levels, lowest pending
// masked bit of the addressed group) is computed from the updated state and
// loaded into the result register. The block takes one transaction every
// cycle; the only limit is the result side, which holds the pipeline while
// it stalls. Lines that select a combined event (0 to 3) follow the OR of
// that group's masked flags; lines that select a raw event pulse high only
// in the result of the raise.
// ----------------------------------------------------------------------------
module event_combiner_interrupt_selector
    import ecis_pkg::*;
#(
    parameter int NUM_GROUPS = 4,
    parameter int NUM_LINES  = 12
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    // Input stage
    logic  s1_valid_reg;
    logic  s1_valid_next;
    item_t s1_item_reg;

    // Result stage
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_res_reg;

    logic    s1_ready;
    logic    advance;
    logic    accept;
    result_t eval_res;
    raise_t  raise;

    logic [NUM_GROUPS-1:0][GROUP_BITS-1:0] flags_next;
    logic [NUM_GROUPS-1:0][GROUP_BITS-1:0] mask_next;
    logic [NUM_LINES-1:0][SEL_W-1:0]       sel_next;

    // Advance the input stage whenever the result register is free or drains
    assign s1_ready   = !out_valid_reg || !result_stall;
    assign advance    = s1_valid_reg && s1_ready;
    assign item_stall = s1_valid_reg && !s1_ready;
    assign accept     = item_valid && !item_stall;

    // State commits only when the transaction moves into the result register
    ecis_state #(
        .NUM_GROUPS (NUM_GROUPS),
        .NUM_LINES  (NUM_LINES)
    ) u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .item       (s1_item_reg),
        .flags_next (flags_next),
        .mask_next  (mask_next),
        .sel_next   (sel_next),
        .raise      (raise)
    );

    // Result is taken from the state after this transaction's update
    ecis_eval #(
        .NUM_GROUPS (NUM_GROUPS),
        .NUM_LINES  (NUM_LINES)
    ) u_eval (
        .item   (s1_item_reg),
        .flags  (flags_next),
        .mask   (mask_next),
        .sel    (sel_next),
        .raise  (raise),
        .result (eval_res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on accept / advance, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
        end
        if (advance)
        begin
            out_res_reg <= eval_res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_res_reg;

    // Anything but a read returns zero read data
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_item_reg.operation != OP_READ |=> result.read_data == '0)
        else $error("read data nonzero for a non-read transaction");

    // Combined events never get flag bits of their own
    assert property (@(posedge clk) disable iff (!rst_n)
        flags_next[0][NUM_COMBINED-1:0] == '0)
        else $error("flag bit of a combined event set");

    // A nonzero pending index implies something is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.first_pending != '0 |-> result.any_pending)
        else $error("first_pending set with nothing pending");

endmodule

// ----- tb/sv/tb_event_combiner_interrupt_selector.sv -----
// ----------------------------------------------------------------------------
// tb_event_combiner_interrupt_selector
// Self-checking bench for the interrupt event combiner and line selector.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the flag, mask and select registers.
// It works out the result of every accepted transaction and checks each
// accepted result, field by field, against the oldest outstanding one. A
// directed opening covers reset values, ignored raises, reserved kinds and
// select words, and bit 7 of the select bytes. A random part follows that
// writes group masks, steers lines onto combined or raised events and
// raises events, so that lines and pending outputs toggle often. The sender
// works in bursts with random gaps. The receiver stalls on a pattern that
// changes from phase to phase.
// ----------------------------------------------------------------------------
module tb_event_combiner_interrupt_selector;
    import ecis_pkg::*;

    localparam logic [1:0] OP_NONE        = 2'd3;   // no register access, no raise
    localparam logic [2:0] KIND_RSVD_LO   = 3'd5;
    localparam logic [2:0] KIND_RSVD_HI   = 3'd7;
    localparam int         RANDOM_ITEMS   = 1330;
    localparam int         DRAIN_LIMIT    = 20000;  // cycles allowed to empty the pipe
    localparam int         TAIL_CYCLES    = 8;      // extra cycles held after the drain for stray results
    localparam int         RUN_LIMIT      = 3000000;

    localparam int STALL_NONE   = 0;
    localparam int STALL_RANDOM = 1;
    localparam int STALL_PERIOD = 2;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the result of each transaction and checks results
    // ------------------------------------------------------------------------
    class irq_scoreboard;
        logic [31:0]      flags [MAX_GROUPS];
        logic [31:0]      mask  [MAX_GROUPS];
        logic [SEL_W-1:0] sel   [MAX_LINES];
        result_t          irq_results_q [$];
        int errors;
        int n_raise, n_write, n_read, n_none;
        int n_checked, n_line_hits, n_pending;

        function new();
            for (int g = 0; g < MAX_GROUPS; g++)
            begin
                flags[g] = '0;
                mask[g]  = '1;
            end
            for (int k = 0; k < MAX_LINES; k++)
                sel[k] = '0;
        endfunction

        function logic [31:0] masked_flags(int g);
            if (g >= MAX_GROUPS)
                return '0;
            return flags[g] & ~mask[g];
        endfunction

        function logic [31:0] select_word(int w);
            logic [31:0] v;
            int          k;
            v = '0;
            if (w == 0)
                return v;
            for (int j = 0; j < 4; j++)
            begin
                k = (w - 1) * 4 + j;
                if (k < MAX_LINES)
                    v[8*j +: 8] = {1'b0, sel[k]};
            end
            return v;
        endfunction

        // Update the register copy with one transaction and queue its result
        function void apply_item(item_t it);
            result_t     exp;
            logic [31:0] pend;
            logic [6:0]  evt;
            int          g, idx, k;
            bit          raised;
            exp    = '0;
            evt    = it.event_number;
            idx    = it.register_index;
            raised = 1'b0;
            case (it.operation)
                OP_RAISE:
                begin
                    n_raise++;
                    g = evt >> 5;
                    if (evt >= NUM_COMBINED && g < MAX_GROUPS)
                    begin
                        flags[g][evt[4:0]] = 1'b1;
                        raised = 1'b1;
                    end
                end
                OP_WRITE:
                begin
                    n_write++;
                    if (it.register_kind == KIND_CLEAR && idx < MAX_GROUPS)
                        flags[idx] = flags[idx] & ~it.write_data;
                    else if (it.register_kind == KIND_MASK && idx < MAX_GROUPS)
                        mask[idx] = it.write_data;
                    else if (it.register_kind == KIND_SELECT && idx != 0)
                    begin
                        for (int j = 0; j < 4; j++)
                        begin
                            k = (idx - 1) * 4 + j;
                            if (k < MAX_LINES)
                                sel[k] = it.write_data[8*j +: SEL_W];
                        end
                    end
                end
                OP_READ:
                begin
                    n_read++;
                    if (it.register_kind == KIND_FLAGS && idx < MAX_GROUPS)
                        exp.read_data = flags[idx];
                    else if (it.register_kind == KIND_MASK && idx < MAX_GROUPS)
                        exp.read_data = mask[idx];
                    else if (it.register_kind == KIND_MASKED)
                        exp.read_data = masked_flags(idx);
                    else if (it.register_kind == KIND_SELECT)
                        exp.read_data = select_word(idx);
                end
                default:
                    n_none++;
            endcase

            // Combined selections follow the group level, raw ones pulse on the raise
            for (k = 0; k < MAX_LINES; k++)
            begin
                if (sel[k] < NUM_COMBINED)
                    exp.interrupt_lines[k] = (masked_flags(sel[k]) != 0);
                else
                    exp.interrupt_lines[k] = raised && (sel[k] == evt);
            end

            pend = masked_flags(idx);
            exp.any_pending = (pend != 0);
            for (int b = GROUP_BITS - 1; b >= 0; b--)
                if (pend[b])
                    exp.first_pending = b[4:0];

            irq_results_q.push_back(exp);
        endfunction

        function int outstanding();
            return irq_results_q.size();
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(result_t got);
            result_t exp;
            if (irq_results_q.size() == 0)
            begin
                report($sformatf("result %h arrived with nothing outstanding", got));
                return;
            end
            exp = irq_results_q.pop_front();
            n_checked++;
            if (got.interrupt_lines != 0)
                n_line_hits++;
            if (got.any_pending)
                n_pending++;
            if (got.read_data !== exp.read_data)
                report($sformatf("read_data got %h want %h", got.read_data, exp.read_data));
            if (got.interrupt_lines !== exp.interrupt_lines)
                report($sformatf("interrupt_lines got %h want %h",
                                 got.interrupt_lines, exp.interrupt_lines));
            if (got.first_pending !== exp.first_pending)
                report($sformatf("first_pending got %0d want %0d",
                                 got.first_pending, exp.first_pending));
            if (got.any_pending !== exp.any_pending)
                report($sformatf("any_pending got %b want %b",
                                 got.any_pending, exp.any_pending));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    irq_scoreboard sb;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    event_combiner_interrupt_selector #(
        .NUM_GROUPS (MAX_GROUPS),
        .NUM_LINES  (MAX_LINES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // ------------------------------------------------------------------------
    // Receiver: stall pattern changes mode after a random span of cycles
    // ------------------------------------------------------------------------
    int stall_mode = STALL_NONE;
    int stall_left = 0;
    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(STALL_NONE, STALL_PERIOD);
            stall_left <= $urandom_range(64, 256);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            STALL_RANDOM: result_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIOD: result_stall <= ((cycle_count % 7) < 3);
            default:      result_stall <= 1'b0;
        endcase
    end

    // Check every result transaction; values here are the ones at the edge
    always @(posedge clk)
    begin
        if (rst_n && sb != null && result_valid && !result_stall)
            sb.check_result(result);
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    function automatic item_t make_item(logic [1:0] op, logic [6:0] evt, logic [2:0] kind,
                                        logic [1:0] idx, logic [31:0] data);
        item_t it;
        it.operation      = op;
        it.event_number   = evt;
        it.register_kind  = kind;
        it.register_index = idx;
        it.write_data     = data;
        return it;
    endfunction

    // Present one transaction and hold it until accepted; valid stays high
    task automatic drive(input item_t it);
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.apply_item(it);
    endtask

    // Select data: mostly combined events 0 to 3, sometimes any byte
    function automatic logic [31:0] select_data();
        logic [31:0] d;
        for (int j = 0; j < 4; j++)
        begin
            if ($urandom_range(0, 9) < 6)
                d[8*j +: 8] = {$urandom_range(0, 1) == 1, 5'd0, 2'($urandom_range(0, 3))};
            else
                d[8*j +: 8] = 8'($urandom_range(0, 255));
        end
        return d;
    endfunction

    // Random transaction biased toward sequences that reach lines and pending bits
    function automatic item_t random_item();
        item_t it;
        int    r;
        it = make_item(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                       3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), $urandom);
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            it.operation = OP_RAISE;
            // half the raises hit an event some line selects
            if ($urandom_range(0, 1) == 1)
                it.event_number = sb.sel[$urandom_range(0, MAX_LINES - 1)];
        end
        else if (r < 70)
        begin
            it.operation = OP_WRITE;
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                it.register_kind = KIND_CLEAR;
                if ($urandom_range(0, 1) == 1)
                    it.write_data = $urandom & $urandom & $urandom;
            end
            else if (r < 60)
            begin
                it.register_kind = KIND_MASK;
                r = $urandom_range(0, 9);
                if (r < 5)
                    it.write_data = $urandom | $urandom;
                else if (r == 8)
                    it.write_data = '0;
                else if (r == 9)
                    it.write_data = '1;
            end
            else if (r < 85)
            begin
                it.register_kind = KIND_SELECT;
                it.write_data    = select_data();
            end
        end
        else if (r < 95)
        begin
            it.operation = OP_READ;
            if ($urandom_range(0, 9) < 8)
                it.register_kind = 3'($urandom_range(KIND_FLAGS, KIND_SELECT));
        end
        else
            it.operation = OP_NONE;
        return it;
    endfunction

    task automatic run_directed();
        // reset values
        drive(make_item(OP_READ,  7'd0,   KIND_FLAGS,  2'd0, 32'h0));
        drive(make_item(OP_READ,  7'd0,   KIND_MASK,   2'd3, 32'h0));
        drive(make_item(OP_READ,  7'd0,   KIND_SELECT, 2'd1, 32'h0));
        // raises of combined events are dropped, raw ones set flags
        drive(make_item(OP_RAISE, 7'd0,   KIND_FLAGS,  2'd0, 32'h0));
        drive(make_item(OP_RAISE, 7'd3,   KIND_FLAGS,  2'd0, 32'h0));
        drive(make_item(OP_RAISE, 7'd4,   KIND_FLAGS,  2'd0, 32'h0));
        drive(make_item(OP_RAISE, 7'd127, KIND_FLAGS,  2'd3, 32'h0));
        // unmask group 0: every line selects event 0 after reset
        drive(make_item(OP_WRITE, 7'd0,   KIND_MASK,   2'd0, 32'h0000_0000));
        drive(make_item(OP_READ,  7'd0,   KIND_MASKED, 2'd0, 32'h0));
        // select word 0 is reserved, bit 7 of each byte is dropped
        drive(make_item(OP_WRITE, 7'd0,   KIND_SELECT, 2'd0, 32'hFFFF_FFFF));
        drive(make_item(OP_WRITE, 7'd0,   KIND_SELECT, 2'd1, 32'h8304_7F05));
        drive(make_item(OP_WRITE, 7'd0,   KIND_SELECT, 2'd3, 32'h0201_8180));
        drive(make_item(OP_READ,  7'd0,   KIND_SELECT, 2'd0, 32'h0));
        drive(make_item(OP_READ,  7'd0,   KIND_SELECT, 2'd1, 32'h0));
        drive(make_item(OP_READ,  7'd0,   KIND_SELECT, 2'd3, 32'h0));
        // lines pulse on the raise of their raw event
        drive(make_item(OP_RAISE, 7'd4,   KIND_FLAGS,  2'd0, 32'h0));
        drive(make_item(OP_RAISE, 7'd127, KIND_FLAGS,  2'd3, 32'h0));
        drive(make_item(OP_WRITE, 7'd0,   KIND_MASK,   2'd3, 32'h0000_0000));
        // clear is write-one-to-clear and write-only
        drive(make_item(OP_WRITE, 7'd0,   KIND_CLEAR,  2'd0, 32'hFFFF_FFFF));
        drive(make_item(OP_READ,  7'd0,   KIND_CLEAR,  2'd3, 32'h0));
        // read-only and reserved kinds, no-op operation
        drive(make_item(OP_WRITE, 7'd0,   KIND_FLAGS,  2'd3, 32'h0));
        drive(make_item(OP_WRITE, 7'd0,   KIND_MASKED, 2'd3, 32'h0));
        drive(make_item(OP_WRITE, 7'd0,   KIND_RSVD_LO, 2'd3, 32'hFFFF_FFFF));
        drive(make_item(OP_READ,  7'd0,   KIND_RSVD_HI, 2'd3, 32'h0));
        drive(make_item(OP_NONE,  7'd100, KIND_MASK,   2'd3, 32'hFFFF_FFFF));
    endtask

    task automatic run_random(input int count);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count)
        begin
            // occasionally a long burst with no gap at all
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100)
                                                : $urandom_range(1, 16);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                drive(random_item());
                sent++;
            end
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int guard;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(RANDOM_ITEMS);
        item_valid <= 1'b0;

        // drain, then hold for TAIL_CYCLES to catch stray results
        guard = 0;
        while (sb.outstanding() > 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (sb.outstanding() > 0)
            sb.report($sformatf("%0d results never arrived", sb.outstanding()));
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("stimulus: %0d raises, %0d writes, %0d reads, %0d no-op transactions",
                 sb.n_raise, sb.n_write, sb.n_read, sb.n_none);
        $display("results: %0d checked, %0d with a line high, %0d with a group pending",
                 sb.n_checked, sb.n_line_hits, sb.n_pending);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hard stop in case the handshake hangs
    initial
    begin
        #RUN_LIMIT;
        $display("timeout: run did not complete");
        $display("CHECK FAILED");
        $finish;
    end

endmodule
